>>> hw/rtl/pbvs_pkg.sv
// Shared widths, register indexes, reset values and types of the vertical shift blit.
`default_nettype none

package pbvs_pkg;

    // Payload and register widths.
    localparam int BYTE_W      = 8;
    localparam int PAGE_W      = 3;
    localparam int SHIFT_W     = 3;
    localparam int COLUMN_W    = 8;
    localparam int ROW_W       = 6;
    localparam int WIDTH_W     = 8;
    localparam int HEIGHT_W    = 7;
    localparam int OFFSET_W    = 2;
    localparam int BAND_W      = 3;
    localparam int BANDS_W     = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Width compares run one bit wider than the width register so that a
    // line length of 256 columns still fits.
    localparam int WCMP_W = WIDTH_W + 1;

    localparam int DEFAULT_MAX_WIDTH = 128;

    localparam logic [BANDS_W-1:0] MAX_BANDS = 4'd8;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_START_COLUMN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ROW     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BITMAP_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BITMAP_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_OFFSET = 3'd4;

    // Register reset values.
    localparam logic [COLUMN_W-1:0] RST_START_COLUMN  = 8'd0;
    localparam logic [ROW_W-1:0]    RST_START_ROW     = 6'd0;
    localparam logic [WIDTH_W-1:0]  RST_BITMAP_WIDTH  = 8'd1;
    localparam logic [HEIGHT_W-1:0] RST_BITMAP_HEIGHT = 7'd1;
    localparam logic [OFFSET_W-1:0] RST_COLUMN_OFFSET = 2'd2;

    // One accepted byte with everything the output stage needs to form its writes.
    typedef struct packed {
        logic [BYTE_W-1:0]   cur;
        logic [COLUMN_W-1:0] addr;
        logic [PAGE_W-1:0]   page;
        logic [SHIFT_W-1:0]  shift;
        logic                first_band;
        logic                last_band;
        logic                final_item;
    } stage_t;

endpackage

`default_nettype wire

>>> hw/rtl/page_bitmap_vertical_shift_blit.sv
// Top level of the page-mode bitmap blit with vertical shift.
//
// Usage: bitmap column bytes enter on the in_valid/in_ready channel, band by
// band, each band bitmap_width columns long. Each byte leaves as one display
// RAM write (page_index, column_address, write_byte) on out_valid/out_ready;
// when the row shift is nonzero, every byte of the last band leaves a second
// write that spills into the next page. last_write marks the bitmap's end.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle; any
// write to a defined register restarts the bitmap.
// Path: an accepted byte is registered in the stage register and then, once the
// output register is free, in the output register that drives the write.
// Throughput: one byte per cycle unless the receiver stalls; a byte with a spill
// write holds the channel while the single output register carries both writes.
// The line store of the previous band is read and written at the accepting
// edge, so back-to-back bytes of the same column never collide.
// Reset clears the counters, the pipeline valids and the configuration to its
// defaults; the line store is not cleared, since the first band fills it.
// When the receiver stalls, the output register holds its write and one more
// byte is taken into the stage register; then in_ready drops.
`default_nettype none

module page_bitmap_vertical_shift_blit
    import pbvs_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [BYTE_W-1:0]      pixel_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [PAGE_W-1:0]           page_index,
    output logic [COLUMN_W-1:0]         column_address,
    output logic [BYTE_W-1:0]           write_byte,
    output logic                        last_write
);

    localparam int CNT_W = $clog2(MAX_WIDTH);

    // Configuration registers.
    logic [COLUMN_W-1:0] start_column_reg;
    logic [ROW_W-1:0]    start_row_reg;
    logic [WIDTH_W-1:0]  bitmap_width_reg;
    logic [HEIGHT_W-1:0] bitmap_height_reg;
    logic [OFFSET_W-1:0] column_offset_reg;
    logic                cfg_hit;

    // Position counters.
    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  col_next;
    logic [BAND_W-1:0] band_reg;
    logic [BAND_W-1:0] band_next;

    // Line store of the previous band and its registered read data.
    logic [BYTE_W-1:0] band_mem [MAX_WIDTH];
    logic [BYTE_W-1:0] above_reg;

    // Stage register and output register.
    logic          stage_valid_reg;
    logic          stage_valid_next;
    stage_t        stage_reg;
    stage_t        stage_next;
    logic          spill_phase_reg;
    logic          spill_phase_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [PAGE_W-1:0]   page_reg;
    logic [PAGE_W-1:0]   page_next;
    logic [COLUMN_W-1:0] addr_reg;
    logic [COLUMN_W-1:0] addr_next;
    logic [BYTE_W-1:0]   byte_reg;
    logic [BYTE_W-1:0]   byte_next;
    logic                last_reg;
    logic                last_next;

    // Accept-side decode.
    logic                in_accept;
    logic [WCMP_W-1:0]   width_ext;
    logic [WCMP_W-1:0]   eff_width;
    logic [WCMP_W-1:0]   col_plus;
    logic                last_col;
    logic [HEIGHT_W-1:0] height_m1;
    logic [BANDS_W:0]    bands_raw;
    logic [BANDS_W-1:0]  eff_bands;
    logic [BANDS_W-1:0]  band_plus;
    logic                last_band;
    logic [WCMP_W-1:0]   addr_sum;

    // Output-side merge.
    logic                out_free;
    logic                stage_load;
    logic                stage_done;
    logic                has_spill;
    logic [BYTE_W-1:0]   above;
    logic [2*BYTE_W-1:0] merge_wide;
    logic [2*BYTE_W-1:0] spill_wide;

    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_START_COLUMN,
                REG_START_ROW,
                REG_BITMAP_WIDTH,
                REG_BITMAP_HEIGHT,
                REG_COLUMN_OFFSET: cfg_hit = 1'b1;
                default:           cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_column_reg  <= RST_START_COLUMN;
            start_row_reg     <= RST_START_ROW;
            bitmap_width_reg  <= RST_BITMAP_WIDTH;
            bitmap_height_reg <= RST_BITMAP_HEIGHT;
            column_offset_reg <= RST_COLUMN_OFFSET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_COLUMN:  start_column_reg  <= cfg_data[COLUMN_W-1:0];
                REG_START_ROW:     start_row_reg     <= cfg_data[ROW_W-1:0];
                REG_BITMAP_WIDTH:  bitmap_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_BITMAP_HEIGHT: bitmap_height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_COLUMN_OFFSET: column_offset_reg <= cfg_data[OFFSET_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective width and band count, with the out-of-range values clamped.
    always_comb
    begin
        width_ext = {1'b0, bitmap_width_reg};
        if (width_ext == '0)
            eff_width = WCMP_W'(1);
        else if (width_ext > WCMP_W'(MAX_WIDTH))
            eff_width = WCMP_W'(MAX_WIDTH);
        else
            eff_width = width_ext;

        height_m1 = bitmap_height_reg - HEIGHT_W'(1);
        bands_raw = (BANDS_W+1)'(height_m1[HEIGHT_W-1:3]) + (BANDS_W+1)'(1);
        if (bitmap_height_reg == '0)
            eff_bands = BANDS_W'(1);
        else if (bands_raw > (BANDS_W+1)'(MAX_BANDS))
            eff_bands = MAX_BANDS;
        else
            eff_bands = bands_raw[BANDS_W-1:0];
    end

    always_comb
    begin
        col_plus  = WCMP_W'(col_reg) + WCMP_W'(1);
        last_col  = col_plus >= eff_width;
        band_plus = {1'b0, band_reg} + BANDS_W'(1);
        last_band = band_plus >= eff_bands;
        addr_sum  = {1'b0, start_column_reg} + WCMP_W'(col_reg)
                  + WCMP_W'(column_offset_reg);

        stage_next.cur        = pixel_byte;
        stage_next.addr       = addr_sum[COLUMN_W-1:0];
        stage_next.page       = start_row_reg[ROW_W-1:SHIFT_W] + band_reg;
        stage_next.shift      = start_row_reg[SHIFT_W-1:0];
        stage_next.first_band = (band_reg == '0);
        stage_next.last_band  = last_band;
        stage_next.final_item = last_band && last_col;

        col_next  = col_reg;
        band_next = band_reg;
        if (cfg_hit)
        begin
            col_next  = '0;
            band_next = '0;
        end
        else if (in_accept)
        begin
            if (last_col)
            begin
                col_next  = '0;
                band_next = last_band ? '0 : band_plus[BAND_W-1:0];
            end
            else
            begin
                col_next = col_plus[CNT_W-1:0];
            end
        end
    end

    // Read-first line store: the byte above comes out as the new byte goes in.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            above_reg         <= band_mem[col_reg];
            band_mem[col_reg] <= pixel_byte;
        end
    end

    always_comb
    begin
        out_free   = !out_valid_reg || out_ready;
        has_spill  = stage_reg.last_band && (stage_reg.shift != '0);
        stage_load = stage_valid_reg && out_free;
        stage_done = stage_load && (!has_spill || spill_phase_reg);
        in_ready   = !stage_valid_reg || stage_done;

        above      = stage_reg.first_band ? '0 : above_reg;
        merge_wide = {stage_reg.cur, above} << stage_reg.shift;
        spill_wide = {{BYTE_W{1'b0}}, stage_reg.cur} << stage_reg.shift;

        stage_valid_next = in_accept ? 1'b1 : (stage_done ? 1'b0 : stage_valid_reg);
        spill_phase_next = stage_load ? (has_spill && !spill_phase_reg) : spill_phase_reg;
        out_valid_next   = stage_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

        page_next = page_reg;
        addr_next = addr_reg;
        byte_next = byte_reg;
        last_next = last_reg;
        if (stage_load)
        begin
            addr_next = stage_reg.addr;
            if (spill_phase_reg)
            begin
                page_next = stage_reg.page + PAGE_W'(1);
                byte_next = spill_wide[2*BYTE_W-1:BYTE_W];
                last_next = stage_reg.final_item;
            end
            else
            begin
                page_next = stage_reg.page;
                byte_next = merge_wide[2*BYTE_W-1:BYTE_W];
                last_next = stage_reg.final_item && (stage_reg.shift == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            band_reg        <= '0;
            stage_valid_reg <= 1'b0;
            spill_phase_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            band_reg        <= band_next;
            stage_valid_reg <= stage_valid_next;
            spill_phase_reg <= spill_phase_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            stage_reg <= stage_next;
        page_reg <= page_next;
        addr_reg <= addr_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign page_index     = page_reg;
    assign column_address = addr_reg;
    assign write_byte     = byte_reg;
    assign last_write     = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pbvs_check.sv
// Port-level checker of the vertical shift blit and its bind to the top level.
`default_nettype none

module pbvs_check
    import pbvs_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [PAGE_W-1:0]   page_index,
    input wire logic [COLUMN_W-1:0] column_address,
    input wire logic [BYTE_W-1:0]   write_byte,
    input wire logic                last_write
);

    // A stalled write stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(page_index)
            && $stable(column_address) && $stable(write_byte) && $stable(last_write))
    else $error("stalled output write changed");

    // The input side only waits while a write is being delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> out_valid)
    else $error("input held off with no write offered");

    // A byte taken during an output stall fills the stage; a second one must wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && in_valid && in_ready |=> out_ready || !in_ready)
    else $error("more bytes taken than the pipeline can hold");

endmodule

bind page_bitmap_vertical_shift_blit pbvs_check u_pbvs_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .page_index     (page_index),
    .column_address (column_address),
    .write_byte     (write_byte),
    .last_write     (last_write)
);

`default_nettype wire

>>> bench/tb_page_bitmap_vertical_shift_blit.sv
// Self-checking testbench of the page-mode bitmap blit with vertical shift.
module tb_page_bitmap_vertical_shift_blit;
    timeunit 1ns;
    timeprecision 1ps;

    import pbvs_pkg::*;

    localparam realtime HALF_PERIOD  = 6.0;
    localparam int      RESET_CYCLES = 8;
    localparam int      LINE_MAX     = DEFAULT_MAX_WIDTH;
    localparam int      RANDOM_ITEMS = 930;
    localparam int      STEADY_ITEMS = 100;
    localparam int      DRAIN_CYCLES = 8;
    localparam int      CYCLE_LIMIT  = 200000;
    localparam int      REPORT_LINES = 100;
    localparam int      N_DIRECTED   = 38;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_COLUMN_OFFSET + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = '1;

    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic [COLUMN_W-1:0] column;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } ram_write_t;

    localparam ram_write_t NO_WRITE = '0;

    typedef enum logic {ROW_CONFIG, ROW_BYTE} row_kind_t;

    // A directed row is a register write or a pixel byte. A nonzero typed
    // count means the expected writes are spelled out in the row.
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
        logic [1:0]             typed;
        ram_write_t             first;
        ram_write_t             spill;
    } stim_row_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [BYTE_W-1:0]      pixel_byte = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [PAGE_W-1:0]      page_index;
    logic [COLUMN_W-1:0]    column_address;
    logic [BYTE_W-1:0]      write_byte;
    logic                   last_write;

    // Shadow of the configuration and of the blit state.
    logic [COLUMN_W-1:0] conf_start_column  = RST_START_COLUMN;
    logic [ROW_W-1:0]    conf_start_row     = RST_START_ROW;
    logic [WIDTH_W-1:0]  conf_width         = RST_BITMAP_WIDTH;
    logic [HEIGHT_W-1:0] conf_height        = RST_BITMAP_HEIGHT;
    logic [OFFSET_W-1:0] conf_column_offset = RST_COLUMN_OFFSET;
    logic [BYTE_W-1:0]   line_store [LINE_MAX];
    int                  column_pos = 0;
    int                  band_pos   = 0;

    ram_write_t  pending_writes [$];
    int          mismatches   = 0;
    int          items_sent   = 0;
    bit          steady_tail  = 1'b0;
    int          ready_hold   = 0;
    int unsigned cycle_count  = 0;
    stim_row_t   directed_rows [N_DIRECTED];

    page_bitmap_vertical_shift_blit uut (
        .clk,
        .rst_n,
        .cfg_we,
        .cfg_index,
        .cfg_data,
        .in_valid,
        .in_ready,
        .pixel_byte,
        .out_valid,
        .out_ready,
        .page_index,
        .column_address,
        .write_byte,
        .last_write
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    function automatic ram_write_t ram_write(input logic [PAGE_W-1:0] page,
                                             input logic [COLUMN_W-1:0] column,
                                             input logic [BYTE_W-1:0] data,
                                             input logic last);
        ram_write_t w;
        w.page   = page;
        w.column = column;
        w.data   = data;
        w.last   = last;
        return w;
    endfunction

    function automatic stim_row_t config_row(input logic [CFG_INDEX_W-1:0] index,
                                             input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_CONFIG;
        row.index = index;
        row.value = value;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [BYTE_W-1:0] value,
                                            input logic [1:0] typed,
                                            input ram_write_t first,
                                            input ram_write_t spill);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_BYTE;
        row.value = value;
        row.typed = typed;
        row.first = first;
        row.spill = spill;
        return row;
    endfunction

    function automatic stim_row_t byte_row(input logic [BYTE_W-1:0] value);
        return typed_row(value, 2'd0, NO_WRITE, NO_WRITE);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < REPORT_LINES)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want,
                     $realtime);
        mismatches++;
    endtask

    // Works out the display writes of one pixel byte and advances the blit state.
    task automatic blit_byte(input logic [BYTE_W-1:0] cur, output ram_write_t first_w,
                             output ram_write_t spill_w, output int count);
        int   width;
        int   bands;
        int   shift;
        int   above;
        int   page0;
        logic last_band;
        logic last_col;
        width = (conf_width == '0) ? 1 : int'(conf_width);
        if (width > LINE_MAX)
            width = LINE_MAX;
        bands = (conf_height == '0) ? 1 : ((int'(conf_height) - 1) >> SHIFT_W) + 1;
        if (bands > int'(MAX_BANDS))
            bands = int'(MAX_BANDS);
        shift = int'(conf_start_row[SHIFT_W-1:0]);
        page0 = int'(conf_start_row[ROW_W-1:SHIFT_W]);
        // The first band has nothing above it.
        above = (band_pos == 0) ? 0 : int'(line_store[column_pos % LINE_MAX]);
        last_band = (band_pos + 1 >= bands);
        last_col  = (column_pos + 1 >= width);

        first_w.page   = PAGE_W'(page0 + band_pos);
        first_w.column = COLUMN_W'(int'(conf_start_column) + column_pos
                                   + int'(conf_column_offset));
        first_w.data   = (shift == 0) ? cur
                         : BYTE_W'((above >> (BYTE_W - shift)) | (int'(cur) << shift));
        first_w.last   = last_band && last_col && (shift == 0);

        spill_w.page   = PAGE_W'(page0 + band_pos + 1);
        spill_w.column = first_w.column;
        spill_w.data   = BYTE_W'(int'(cur) >> (BYTE_W - shift));
        spill_w.last   = last_band && last_col;

        count = (last_band && shift != 0) ? 2 : 1;

        line_store[column_pos % LINE_MAX] = cur;
        if (last_col) begin
            column_pos = 0;
            band_pos   = last_band ? 0 : band_pos + 1;
        end else begin
            column_pos = column_pos + 1;
        end
    endtask

    // Drives one register write; the caller lowers the write enable afterwards.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            REG_START_COLUMN:  conf_start_column  = value;
            REG_START_ROW:     conf_start_row     = value[ROW_W-1:0];
            REG_BITMAP_WIDTH:  conf_width         = value;
            REG_BITMAP_HEIGHT: conf_height        = value[HEIGHT_W-1:0];
            REG_COLUMN_OFFSET: conf_column_offset = value[OFFSET_W-1:0];
            default:           return;
        endcase
        column_pos = 0;
        band_pos   = 0;
    endtask

    task automatic wait_drained();
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic [1:0] typed,
                             input ram_write_t typed_first, input ram_write_t typed_spill,
                             output logic ended);
        ram_write_t first_w;
        ram_write_t spill_w;
        int         count;
        cfg_we     <= 1'b0;
        in_valid   <= 1'b1;
        pixel_byte <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        blit_byte(value, first_w, spill_w, count);
        if (typed != 2'd0) begin
            first_w = typed_first;
            spill_w = typed_spill;
            count   = int'(typed);
        end
        pending_writes.push_back(first_w);
        if (count == 2)
            pending_writes.push_back(spill_w);
        ended = (count == 2) ? spill_w.last : first_w.last;
        items_sent++;
    endtask

    task automatic send_random_pixel(input bit gappy, input int random_start,
                                     output logic ended);
        logic [BYTE_W-1:0] value;
        case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            default: value = BYTE_W'($urandom);
        endcase
        send_byte(value, 2'd0, NO_WRITE, NO_WRITE, ended);
        steady_tail = (items_sent - random_start >= RANDOM_ITEMS - STEADY_ITEMS);
        if (gappy && !steady_tail && $urandom_range(0, 3) == 0)
            sender_gap();
    endtask

    // The receiver alternates stall bursts with stretches of steady acceptance.
    always @(posedge clk) begin
        if (steady_tail) begin
            out_ready  <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 8);
        end else begin
            out_ready  <= 1'b1;
            ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12);
        end
    end

    always @(posedge clk) begin : write_monitor
        ram_write_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_writes.size() == 0) begin
                report_mismatch("write with none expected, column", column_address, 0);
            end else begin
                want = pending_writes.pop_front();
                if (page_index !== want.page)
                    report_mismatch("page_index", page_index, want.page);
                if (column_address !== want.column)
                    report_mismatch("column_address", column_address, want.column);
                if (write_byte !== want.data)
                    report_mismatch("write_byte", write_byte, want.data);
                if (last_write !== want.last)
                    report_mismatch("last_write", last_write, want.last);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic                   ended;
        logic                   wide_line;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
        bit                     gappy;
        int                     goal;
        int                     finished;
        int                     random_start;

        directed_rows = '{
            // Defaults: one column, one band, no shift, column offset 2.
            typed_row(8'h00, 2'd1, ram_write(3'd0, 8'd2, 8'h00, 1'b1), NO_WRITE),
            typed_row(8'hFF, 2'd1, ram_write(3'd0, 8'd2, 8'hFF, 1'b1), NO_WRITE),
            config_row(REG_START_ROW, 8'h03),
            typed_row(8'h81, 2'd2, ram_write(3'd0, 8'd2, 8'h08, 1'b0),
                      ram_write(3'd1, 8'd2, 8'h04, 1'b1)),
            // Upper data bits are dropped: page 7 with the largest shift.
            config_row(REG_START_ROW, 8'hFF),
            typed_row(8'hFF, 2'd2, ram_write(3'd7, 8'd2, 8'h80, 1'b0),
                      ram_write(3'd0, 8'd2, 8'h7F, 1'b1)),
            config_row(REG_START_COLUMN, 8'hFF),
            config_row(REG_COLUMN_OFFSET, 8'hFF),
            config_row(REG_BITMAP_WIDTH, 8'h00),
            // The column address wraps past 255.
            typed_row(8'h01, 2'd2, ram_write(3'd7, 8'd2, 8'h80, 1'b0),
                      ram_write(3'd0, 8'd2, 8'h00, 1'b1)),
            config_row(REG_START_ROW, 8'h0D),
            config_row(REG_START_COLUMN, 8'h00),
            config_row(REG_COLUMN_OFFSET, 8'h00),
            config_row(REG_BITMAP_WIDTH, 8'h02),
            config_row(REG_BITMAP_HEIGHT, 8'h09),
            byte_row(8'hA5), byte_row(8'h3C), byte_row(8'h0F), byte_row(8'hF0),
            config_row(REG_BITMAP_HEIGHT, 8'h00),
            config_row(REG_BITMAP_WIDTH, 8'h03),
            config_row(REG_START_ROW, 8'h00),
            // Writes to undefined indexes must not restart the bitmap.
            byte_row(8'h55),
            config_row(REG_UNUSED_FIRST, 8'hFF),
            byte_row(8'hAA),
            config_row(REG_UNUSED_LAST, 8'h00),
            byte_row(8'h7E),
            config_row(REG_BITMAP_HEIGHT, 8'h7F),
            config_row(REG_BITMAP_WIDTH, 8'h01),
            config_row(REG_START_ROW, 8'h3C),
            byte_row(8'h11), byte_row(8'h22), byte_row(8'h44), byte_row(8'h88),
            byte_row(8'hF0), byte_row(8'h0F), byte_row(8'hC3), byte_row(8'h3C)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                in_valid <= 1'b0;
                wait_drained();
                write_register(directed_rows[i].index, directed_rows[i].value);
            end else begin
                send_byte(directed_rows[i].value, directed_rows[i].typed,
                          directed_rows[i].first, directed_rows[i].spill, ended);
                if ($urandom_range(0, 3) == 0)
                    sender_gap();
            end
        end
        in_valid <= 1'b0;

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            wait_drained();
            wide_line = 1'b0;
            // Width and height are written every time, which also keeps bitmaps short.
            for (int r = 0; r <= int'(REG_COLUMN_OFFSET); r++) begin
                index = CFG_INDEX_W'(r);
                if (index != REG_BITMAP_WIDTH && index != REG_BITMAP_HEIGHT
                        && $urandom_range(0, 1) == 0)
                    continue;
                case (index)
                    REG_START_COLUMN: begin
                        case ($urandom_range(0, 5))
                            0:       value = '0;
                            1:       value = CFG_DATA_W'(131);
                            2:       value = CFG_DATA_W'($urandom_range(132, 255));
                            default: value = CFG_DATA_W'($urandom_range(0, 131));
                        endcase
                    end
                    REG_START_ROW: begin
                        case ($urandom_range(0, 5))
                            0:       value = '0;
                            1:       value = CFG_DATA_W'(63);
                            2:       value = CFG_DATA_W'($urandom_range(64, 255));
                            default: value = CFG_DATA_W'($urandom_range(0, 63));
                        endcase
                    end
                    REG_BITMAP_WIDTH: begin
                        case ($urandom_range(0, 9))
                            0:       value = CFG_DATA_W'(1);
                            1:       value = CFG_DATA_W'(LINE_MAX);
                            2:       value = '0;
                            3:       value = CFG_DATA_W'($urandom_range(129, 255));
                            4:       value = CFG_DATA_W'($urandom_range(17, 127));
                            default: value = CFG_DATA_W'($urandom_range(1, 16));
                        endcase
                        wide_line = (value > CFG_DATA_W'(16));
                    end
                    REG_BITMAP_HEIGHT: begin
                        if (wide_line) begin
                            value = CFG_DATA_W'($urandom_range(0, 8));
                        end else begin
                            case ($urandom_range(0, 7))
                                0:       value = CFG_DATA_W'(1);
                                1:       value = CFG_DATA_W'(64);
                                2:       value = '0;
                                3:       value = CFG_DATA_W'($urandom_range(65, 255));
                                default: value = CFG_DATA_W'($urandom_range(1, 64));
                            endcase
                        end
                    end
                    default: begin
                        value = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                            : CFG_DATA_W'($urandom_range(0, 3));
                    end
                endcase
                write_register(index, value);
            end
            if ($urandom_range(0, 7) == 0)
                write_register(CFG_INDEX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                               CFG_DATA_W'($urandom));

            gappy = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                // A bitmap cut short; the next register write starts over.
                repeat ($urandom_range(1, 24))
                    send_random_pixel(gappy, random_start, ended);
            end else begin
                goal     = wide_line ? 1 : $urandom_range(1, 2);
                finished = 0;
                while (finished < goal) begin
                    send_random_pixel(gappy, random_start, ended);
                    if (ended)
                        finished++;
                end
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
